@@ rtl/rafrp_pkg.sv @@
// ----------------------------------------------------------------------------
// rafrp_pkg
// Constants for the radio API frame receive parser: frame delimiter,
// decoded API identifiers, result kind codes and the body position limit.
// ----------------------------------------------------------------------------
`default_nettype none

package rafrp_pkg;

    // frame delimiter and checksum base
    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;

    // decoded API identifiers
    localparam logic [7:0] ID_RX16   = 8'h80;
    localparam logic [7:0] ID_RX48   = 8'h81;
    localparam logic [7:0] ID_ATRESP = 8'h88;
    localparam logic [7:0] ID_TXSTAT = 8'h89;

    // result kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_DATA   = 2'd0;
    localparam kind_t KIND_RX_END = 2'd1;
    localparam kind_t KIND_AT_END = 2'd2;
    localparam kind_t KIND_TX_END = 2'd3;

    // body position saturation limit
    localparam logic [3:0] POS_MAX = 4'd15;

endpackage

`default_nettype wire

@@ rtl/radio_api_frame_receive_parser_top.sv @@
// ----------------------------------------------------------------------------
// radio_api_frame_receive_parser_top
// Receive-side API frame parser: one serial byte in, at most one result out.
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one received serial byte per word (s_rx_byte)
//   m_ channel: one result word per data byte or per frame end; kind tells
//     which fields carry meaning, all other fields read as zero
//   each accepted byte is parsed in the cycle it is accepted; its result, if
//     any, is registered and appears on the m_ side in the next cycle
//   throughput: one byte per cycle, sustained, while the receiver keeps up
//   the parser state and the single output register are the only storage;
//     s_ready is high whenever the output register is empty or being drained
//   receiver stall: a waiting result holds in the output register and s_ready
//     drops, so no further byte is taken until the result is accepted
//   reset (aresetn low, synchronous): output register empty, parser hunts for
//     the start byte, running sum and all held header fields clear to zero
//   bytes that produce no result (header bytes, unknown ids, hunting) are
//     still taken one per cycle while s_ready is high and leave the m_ side empty
// ----------------------------------------------------------------------------
`default_nettype none

module radio_api_frame_receive_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // received byte stream
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // parsed results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic [7:0]       m_fid,
    output logic [47:0]      m_src_addr,
    output logic             m_long_address,
    output logic [7:0]       m_rssi,
    output logic [7:0]       m_options,
    output logic [15:0]      m_at_command,
    output logic [7:0]       m_status,
    output logic             m_checksum_ok
);

    // parser phases
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LEN_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_API    = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_CSUM   = 3'd5;

    // parser state
    logic [2:0]  phase_reg,     phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [3:0]  body_pos_reg,  body_pos_next;
    logic [7:0]  sum_reg,       sum_next;
    logic [7:0]  api_id_reg,    api_id_next;
    logic [7:0]  fid_reg,       fid_next;
    logic [47:0] address_reg,   address_next;
    logic [7:0]  rssi_reg,      rssi_next;
    logic [7:0]  options_reg,   options_next;
    logic [15:0] command_reg,   command_next;
    logic [7:0]  status_reg,    status_next;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [7:0]  out_data_reg;
    logic [7:0]  out_fid_reg;
    logic [47:0] out_address_reg;
    logic        out_long_reg;
    logic [7:0]  out_rssi_reg;
    logic [7:0]  out_options_reg;
    logic [15:0] out_command_reg;
    logic [7:0]  out_status_reg;
    logic        out_ok_reg;

    // result of the byte being accepted
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [7:0]  res_data;
    logic [7:0]  res_fid;
    logic [47:0] res_address;
    logic        res_long;
    logic [7:0]  res_rssi;
    logic [7:0]  res_options;
    logic [15:0] res_command;
    logic [7:0]  res_status;
    logic        res_ok;

    logic        accept;
    logic        is_rx;
    logic        is_long;
    logic [3:0]  addr_len;
    logic [15:0] bytes_left_dec;
    logic [7:0]  sum_add;
    logic        csum_match;

    // output register can take a new word when empty or being drained
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_long        = (api_id_reg == rafrp_pkg::ID_RX48);
    assign is_rx          = (api_id_reg == rafrp_pkg::ID_RX16) || is_long;
    assign addr_len       = is_long ? 4'd6 : 4'd2;
    assign bytes_left_dec = bytes_left_reg - 16'd1;
    assign sum_add        = sum_reg + s_rx_byte;
    assign csum_match     = ((rafrp_pkg::CSUM_BASE - sum_reg) == s_rx_byte);

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        body_pos_next   = body_pos_reg;
        sum_next        = sum_reg;
        api_id_next     = api_id_reg;
        fid_next        = fid_reg;
        address_next    = address_reg;
        rssi_next       = rssi_reg;
        options_next    = options_reg;
        command_next    = command_reg;
        status_next     = status_reg;

        res_valid    = 1'b0;
        res_kind     = rafrp_pkg::KIND_DATA;
        res_data     = 8'd0;
        res_fid      = 8'd0;
        res_address  = 48'd0;
        res_long     = 1'b0;
        res_rssi     = 8'd0;
        res_options  = 8'd0;
        res_command  = 16'd0;
        res_status   = 8'd0;
        res_ok       = 1'b0;

        unique case (phase_reg)
            PH_LEN_HI: begin
                bytes_left_next = {s_rx_byte, 8'd0};
                phase_next      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                bytes_left_next = {bytes_left_reg[15:8], s_rx_byte};
                sum_next        = 8'd0;
                api_id_next     = 8'd0;
                phase_next      = ({bytes_left_reg[15:8], s_rx_byte} == 16'd0)
                                  ? PH_CSUM : PH_API;
            end
            PH_API: begin
                api_id_next     = s_rx_byte;
                sum_next        = s_rx_byte;
                body_pos_next   = 4'd0;
                fid_next        = 8'd0;
                address_next    = 48'd0;
                rssi_next       = 8'd0;
                options_next    = 8'd0;
                command_next    = 16'd0;
                status_next     = 8'd0;
                bytes_left_next = bytes_left_dec;
                phase_next      = (bytes_left_dec == 16'd0) ? PH_CSUM : PH_BODY;
            end
            PH_BODY: begin
                sum_next = sum_add;
                if (is_rx) begin
                    if (body_pos_reg == 4'd0) begin
                        fid_next = s_rx_byte;
                    end else if (body_pos_reg <= addr_len) begin
                        address_next = {address_reg[39:0], s_rx_byte};
                    end else if (body_pos_reg == addr_len + 4'd1) begin
                        rssi_next = s_rx_byte;
                    end else if (body_pos_reg == addr_len + 4'd2) begin
                        options_next = s_rx_byte;
                    end else begin
                        res_valid = 1'b1;
                    end
                end else if (api_id_reg == rafrp_pkg::ID_ATRESP) begin
                    if (body_pos_reg == 4'd0) begin
                        fid_next = s_rx_byte;
                    end else if (body_pos_reg == 4'd1) begin
                        command_next = {s_rx_byte, command_reg[7:0]};
                    end else if (body_pos_reg == 4'd2) begin
                        command_next = {command_reg[15:8], s_rx_byte};
                    end else if (body_pos_reg == 4'd3) begin
                        status_next = s_rx_byte;
                    end else begin
                        res_valid = 1'b1;
                    end
                end else if (api_id_reg == rafrp_pkg::ID_TXSTAT) begin
                    if (body_pos_reg == 4'd0) begin
                        fid_next = s_rx_byte;
                    end else if (body_pos_reg == 4'd1) begin
                        status_next = s_rx_byte;
                    end
                end
                // data bytes carry only the byte itself
                if (res_valid) begin
                    res_data = s_rx_byte;
                end
                if (body_pos_reg != rafrp_pkg::POS_MAX) begin
                    body_pos_next = body_pos_reg + 4'd1;
                end
                bytes_left_next = bytes_left_dec;
                if (bytes_left_dec == 16'd0) begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM: begin
                if (is_rx) begin
                    res_valid   = 1'b1;
                    res_kind    = rafrp_pkg::KIND_RX_END;
                    res_address = address_reg;
                    res_long    = is_long;
                    res_rssi    = rssi_reg;
                    res_options = options_reg;
                end else if (api_id_reg == rafrp_pkg::ID_ATRESP) begin
                    res_valid   = 1'b1;
                    res_kind    = rafrp_pkg::KIND_AT_END;
                    res_command = command_reg;
                    res_status  = status_reg;
                end else if (api_id_reg == rafrp_pkg::ID_TXSTAT) begin
                    res_valid   = 1'b1;
                    res_kind    = rafrp_pkg::KIND_TX_END;
                    res_status  = status_reg;
                end
                if (res_valid) begin
                    res_fid = fid_reg;
                    res_ok  = csum_match;
                end
                phase_next = PH_HUNT;
            end
            default: begin
                // hunting: only the delimiter starts a frame
                phase_next = (s_rx_byte == rafrp_pkg::START_BYTE) ? PH_LEN_HI : PH_HUNT;
            end
        endcase
    end

    // parser state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= 16'd0;
            body_pos_reg   <= 4'd0;
            sum_reg        <= 8'd0;
            api_id_reg     <= 8'd0;
            fid_reg        <= 8'd0;
            address_reg    <= 48'd0;
            rssi_reg       <= 8'd0;
            options_reg    <= 8'd0;
            command_reg    <= 16'd0;
            status_reg     <= 8'd0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            body_pos_reg   <= body_pos_next;
            sum_reg        <= sum_next;
            api_id_reg     <= api_id_next;
            fid_reg        <= fid_next;
            address_reg    <= address_next;
            rssi_reg       <= rssi_next;
            options_reg    <= options_next;
            command_reg    <= command_next;
            status_reg     <= status_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            out_kind_reg     <= res_kind;
            out_data_reg     <= res_data;
            out_fid_reg      <= res_fid;
            out_address_reg  <= res_address;
            out_long_reg     <= res_long;
            out_rssi_reg     <= res_rssi;
            out_options_reg  <= res_options;
            out_command_reg  <= res_command;
            out_status_reg   <= res_status;
            out_ok_reg       <= res_ok;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_data_byte      = out_data_reg;
    assign m_fid            = out_fid_reg;
    assign m_src_addr       = out_address_reg;
    assign m_long_address   = out_long_reg;
    assign m_rssi           = out_rssi_reg;
    assign m_options        = out_options_reg;
    assign m_at_command     = out_command_reg;
    assign m_status         = out_status_reg;
    assign m_checksum_ok    = out_ok_reg;

`ifndef SYNTHESIS
    // hunting never yields a result word
    a_hunt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && phase_reg == PH_HUNT) |=> !m_valid)
        else $error("result produced while hunting for start byte");

    // length bytes never yield a result word
    a_len_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (phase_reg == PH_LEN_HI || phase_reg == PH_LEN_LO))
        |=> !m_valid)
        else $error("result produced on a length byte");

    // checksum byte always returns the parser to hunting
    a_csum_to_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && phase_reg == PH_CSUM) |=> (phase_reg == PH_HUNT))
        else $error("parser did not return to hunting after checksum byte");

    // long address flag only on a receive packet end
    a_long_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_long_address) |-> (m_kind == rafrp_pkg::KIND_RX_END))
        else $error("long address flag on a non-receive result");
`endif

endmodule

`default_nettype wire
